[src/rhsv_pkg.sv]
// Package for the RGB to HSV pixel converter: pipeline word types and hue constants.
// Depends on nothing; used by rgb_to_hsv_pixel.

package rhsv_pkg;

  // Quotient bits produced by the divider, one per pipeline stage.
  localparam int DivSteps = 8;
  localparam int HueNumW  = 14;  // 30 * t, t <= 510
  localparam int SatNumW  = 16;  // 255 * d, d <= 255
  localparam int TrialW   = 17;  // width of a trial subtraction

  // Hue offsets, already halved. The chroma term adds floor(30 * t / d) on top.
  localparam logic [7:0] HueGrey     = 8'd120;
  localparam logic [7:0] HueBaseBlue = 8'd90;
  localparam logic [7:0] HueBaseGrn  = 8'd30;
  localparam logic [7:0] HueBaseRed  = 8'd0;
  localparam logic [7:0] HueBaseWrap = 8'd150;

  // Word after the extremum stage.
  typedef struct packed {
    logic       grey;
    logic [7:0] hue_base;
    logic [7:0] mx;
    logic [7:0] d;
    logic [8:0] t;
  } pre_t;

  // Word travelling through the divider stages.
  typedef struct packed {
    logic               grey;
    logic [7:0]         hue_base;
    logic [7:0]         mx;
    logic [7:0]         d;
    logic [HueNumW-1:0] rem_h;
    logic [7:0]         q_h;
    logic [SatNumW-1:0] rem_s;
    logic [7:0]         q_s;
  } div_t;

endpackage

[src/rgb_to_hsv_pixel.sv]
// Pipelined RGB to HSV converter for 8-bit pixels, one word per clock unless out_ready stalls it.
// Throughput: one word per cycle while the output is not stalled; the restoring divider has eight stages.
// Stalls ripple back stage by stage, so bubbles are squeezed out before input stalls.
// Reset: synchronous, active low rst_n clears every stage valid bit.
// Depends on rhsv_pkg.

module rgb_to_hsv_pixel (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_green,
  input  logic [7:0] in_red,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_hue,
  output logic [7:0] out_saturation,
  output logic [7:0] out_brightness
);

  // Stage 0 finds the extremes, stage 1 forms the two numerators, stages
  // 2 to 9 each resolve one quotient bit of both divisions, stage 10 is the
  // output register.
  localparam int NumStages = rhsv_pkg::DivSteps + 3;
  localparam int LastStage = NumStages - 1;

  logic [NumStages-1:0] vld_r;
  logic [NumStages-1:0] en;

  rhsv_pkg::pre_t pre_r, pre_nxt;
  rhsv_pkg::div_t div_r   [0:rhsv_pkg::DivSteps];
  rhsv_pkg::div_t div_nxt [0:rhsv_pkg::DivSteps];

  logic [7:0] hue_r, hue_nxt;
  logic [7:0] sat_r, sat_nxt;
  logic [7:0] val_r;

  // A stage may load when it is empty or its word moves on in this cycle.
  always_comb begin
    en[LastStage] = !vld_r[LastStage] || out_ready;
    for (int k = LastStage - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Extremum stage. Blue wins ties, then green, which also makes a grey
  // pixel take the blue branch. Every hue case is rewritten as
  // base + floor(30 * t / d) with 0 <= t <= 2d so the divider never sees a
  // negative numerator.
  always_comb begin
    logic       b_max;
    logic       g_max;
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] d;
    b_max = (in_blue >= in_green) && (in_blue >= in_red);
    g_max = !b_max && (in_green >= in_red);
    if (b_max) begin
      mx = in_blue;
    end else if (g_max) begin
      mx = in_green;
    end else begin
      mx = in_red;
    end
    if ((in_blue <= in_green) && (in_blue <= in_red)) begin
      mn = in_blue;
    end else if (in_green <= in_red) begin
      mn = in_green;
    end else begin
      mn = in_red;
    end
    d = mx - mn;
    pre_nxt.mx   = mx;
    pre_nxt.d    = d;
    pre_nxt.grey = (d == 8'd0);
    priority if (b_max) begin
      pre_nxt.hue_base = rhsv_pkg::HueBaseBlue;
      pre_nxt.t        = {1'b0, in_red} - {1'b0, in_green} + {1'b0, d};
    end else if (g_max) begin
      pre_nxt.hue_base = rhsv_pkg::HueBaseGrn;
      pre_nxt.t        = {1'b0, in_blue} - {1'b0, in_red} + {1'b0, d};
    end else if (in_green >= in_blue) begin
      pre_nxt.hue_base = rhsv_pkg::HueBaseRed;
      pre_nxt.t        = {1'b0, in_green} - {1'b0, in_blue};
    end else begin
      // Red largest with blue above green: the angle wraps past 360.
      pre_nxt.hue_base = rhsv_pkg::HueBaseWrap;
      pre_nxt.t        = {1'b0, d} + {1'b0, in_green} - {1'b0, in_blue};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pre_r <= pre_nxt;
    end
  end

  // Numerator stage: 30 * t and 255 * d by shift and subtract.
  always_comb begin
    div_nxt[0].grey     = pre_r.grey;
    div_nxt[0].hue_base = pre_r.hue_base;
    div_nxt[0].mx       = pre_r.mx;
    div_nxt[0].d        = pre_r.d;
    div_nxt[0].rem_h    = {pre_r.t, 5'b0} - {4'b0, pre_r.t, 1'b0};
    div_nxt[0].q_h      = 8'd0;
    div_nxt[0].rem_s    = {pre_r.d, 8'b0} - {8'b0, pre_r.d};
    div_nxt[0].q_s      = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      div_r[0] <= div_nxt[0];
    end
  end

  // Restoring division, most significant quotient bit first. The hue
  // divides by d, the saturation by the maximum.
  for (genvar k = 0; k < rhsv_pkg::DivSteps; k++) begin : g_div
    localparam int Shift = rhsv_pkg::DivSteps - 1 - k;

    logic [rhsv_pkg::TrialW-1:0] trial_h;
    logic [rhsv_pkg::TrialW-1:0] trial_s;

    always_comb begin
      trial_h = {3'b0, div_r[k].rem_h} - ({9'b0, div_r[k].d} << Shift);
      trial_s = {1'b0, div_r[k].rem_s} - ({9'b0, div_r[k].mx} << Shift);
      div_nxt[k+1] = div_r[k];
      if (!trial_h[rhsv_pkg::TrialW-1]) begin
        div_nxt[k+1].rem_h        = trial_h[rhsv_pkg::HueNumW-1:0];
        div_nxt[k+1].q_h[Shift]   = 1'b1;
      end
      if (!trial_s[rhsv_pkg::TrialW-1]) begin
        div_nxt[k+1].rem_s        = trial_s[rhsv_pkg::SatNumW-1:0];
        div_nxt[k+1].q_s[Shift]   = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k+2]) begin
        div_r[k+1] <= div_nxt[k+1];
      end
    end
  end

  // Output stage. A grey pixel divides by zero above, so its quotients
  // are discarded here in favour of the fixed grey answer.
  always_comb begin
    if (div_r[rhsv_pkg::DivSteps].grey) begin
      hue_nxt = rhsv_pkg::HueGrey;
      sat_nxt = 8'd0;
    end else begin
      hue_nxt = div_r[rhsv_pkg::DivSteps].hue_base + div_r[rhsv_pkg::DivSteps].q_h;
      sat_nxt = div_r[rhsv_pkg::DivSteps].q_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LastStage]) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= div_r[rhsv_pkg::DivSteps].mx;
    end
  end

  assign out_valid      = vld_r[LastStage];
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = val_r;

`ifndef SYNTHESIS
  // The hue chroma quotient never exceeds sixty for a coloured pixel.
  a_hue_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LastStage-1] && !div_r[rhsv_pkg::DivSteps].grey)
      |-> (div_r[rhsv_pkg::DivSteps].q_h <= 8'd60))
    else $error("hue quotient out of range");

  // The delivered hue always lies in 0..179.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue <= 8'd179))
    else $error("hue above 179");

  // A black pixel is grey: no saturation and the grey hue.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_brightness == 8'd0))
      |-> ((out_saturation == 8'd0) && (out_hue == rhsv_pkg::HueGrey)))
    else $error("black pixel gave colour");

  // With the output free the pipeline never refuses input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with output free");
`endif

endmodule
